/* rtl/hdc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdc_pkg: shared types and constants of the hash distance classifier
// Word layouts, configuration register map, reset values and verdict codes.
// ----------------------------------------------------------------------------
package hdc_pkg;

  // Field widths
  localparam int unsigned ByteW  = 8;
  localparam int unsigned DistW  = 15;
  localparam int unsigned LimitW = 14;
  localparam int unsigned VerdW  = 2;
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 15;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_MATCH_THR = 4'd0,
    REG_CLOSE_THR = 4'd1,
    REG_SPAN_THR  = 4'd2,
    REG_STOP_LIM  = 4'd3
  } cfg_reg_e;

  // Verdict codes
  typedef enum logic [VerdW-1:0] {
    VERDICT_NONE  = 2'd0,
    VERDICT_MATCH = 2'd1,
    VERDICT_CLOSE = 2'd2
  } verdict_e;

  // Reset values of the configuration registers
  localparam logic [DistW-1:0]  MatchThrRst = 15'd100;
  localparam logic [DistW-1:0]  CloseThrRst = 15'd400;
  localparam logic [ByteW-1:0]  SpanThrRst  = 8'd35;
  localparam logic [LimitW-1:0] StopLimRst  = 14'd450;

  // Starting values of the per-comparison extrema
  localparam logic [ByteW-1:0] LowInit  = 8'd255;
  localparam logic [ByteW-1:0] HighInit = 8'd0;

  // Input word: one byte pair
  typedef struct packed {
    logic [ByteW-1:0] byte_a;
    logic [ByteW-1:0] byte_b;
    logic             last;
  } in_word_t;

  // Output word: one classification
  typedef struct packed {
    logic [DistW-1:0] distance;
    logic [VerdW-1:0] verdict;
    logic [ByteW-1:0] span_first;
    logic [ByteW-1:0] span_second;
  } out_word_t;

  // Accumulated totals handed from the accumulator to the classifier
  typedef struct packed {
    logic [DistW-1:0] distance;
    logic [ByteW-1:0] span_first;
    logic [ByteW-1:0] span_second;
  } sum_t;

  // Configuration register set
  typedef struct packed {
    logic [DistW-1:0]  match_thr;
    logic [DistW-1:0]  close_thr;
    logic [ByteW-1:0]  span_thr;
    logic [LimitW-1:0] stop_lim;
  } cfg_t;

endpackage

/* rtl/hdc_accum.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdc_accum: running sum of absolute differences and byte extrema
// Adds |a - b| while the sum is below the stop limit, tracks min/max of each
// hash, and on the last word hands the totals to the classifier stage.
// ----------------------------------------------------------------------------
module hdc_accum (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [hdc_pkg::LimitW-1:0] stop_lim_i,
  input  logic                    in_valid_i,
  input  hdc_pkg::in_word_t       in_word_i,
  output logic                    in_ready_o,
  output logic                    res_valid_o,
  output hdc_pkg::sum_t           res_o,
  input  logic                    res_ready_i
);
  import hdc_pkg::*;

  logic [DistW-1:0] sum_q, sum_d, sum_upd;
  logic [ByteW-1:0] low_a_q, low_a_d, high_a_q, high_a_d;
  logic [ByteW-1:0] low_b_q, low_b_d, high_b_q, high_b_d;
  logic [ByteW-1:0] diff;
  logic             res_valid_q, res_valid_d;
  sum_t             res_q;
  logic             fire, fire_last;

  // Take non-last words always; a last word needs the result slot free or draining
  assign in_ready_o = !in_word_i.last || !res_valid_q || res_ready_i;
  assign fire       = in_valid_i && in_ready_o;
  assign fire_last  = fire && in_word_i.last;

  // Absolute difference and frozen-after-limit sum
  always_comb begin
    if (in_word_i.byte_a >= in_word_i.byte_b) begin
      diff = in_word_i.byte_a - in_word_i.byte_b;
    end else begin
      diff = in_word_i.byte_b - in_word_i.byte_a;
    end
    if (sum_q < {1'b0, stop_lim_i}) begin
      sum_upd = sum_q + {{(DistW-ByteW){1'b0}}, diff};
    end else begin
      sum_upd = sum_q;
    end
  end

  // Extrema update
  always_comb begin
    low_a_d  = (in_word_i.byte_a < low_a_q)  ? in_word_i.byte_a : low_a_q;
    high_a_d = (in_word_i.byte_a > high_a_q) ? in_word_i.byte_a : high_a_q;
    low_b_d  = (in_word_i.byte_b < low_b_q)  ? in_word_i.byte_b : low_b_q;
    high_b_d = (in_word_i.byte_b > high_b_q) ? in_word_i.byte_b : high_b_q;
    sum_d    = sum_upd;
  end

  // Hold the running state; clear it after the last word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q    <= '0;
      low_a_q  <= LowInit;
      high_a_q <= HighInit;
      low_b_q  <= LowInit;
      high_b_q <= HighInit;
    end else if (fire_last) begin
      sum_q    <= '0;
      low_a_q  <= LowInit;
      high_a_q <= HighInit;
      low_b_q  <= LowInit;
      high_b_q <= HighInit;
    end else if (fire) begin
      sum_q    <= sum_d;
      low_a_q  <= low_a_d;
      high_a_q <= high_a_d;
      low_b_q  <= low_b_d;
      high_b_q <= high_b_d;
    end
  end

  // Result slot valid
  always_comb begin
    res_valid_d = res_valid_q;
    if (fire_last) begin
      res_valid_d = 1'b1;
    end else if (res_ready_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  // Capture the totals of a finished comparison
  always_ff @(posedge clk_i) begin
    if (fire_last) begin
      res_q.distance    <= sum_d;
      res_q.span_first  <= high_a_d - low_a_d;
      res_q.span_second <= high_b_d - low_b_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // State is back at its start values after a last word
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_last |=> (sum_q == '0) && (low_a_q == LowInit) && (high_b_q == HighInit))
    else $error("accumulator state not cleared after last word");

  // Extrema of the first hash stay ordered once a byte has been seen
  a_order_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (low_a_q <= high_a_q) || ((low_a_q == LowInit) && (high_a_q == HighInit)))
    else $error("first hash extrema out of order");

  // Extrema of the second hash stay ordered once a byte has been seen
  a_order_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (low_b_q <= high_b_q) || ((low_b_q == LowInit) && (high_b_q == HighInit)))
    else $error("second hash extrema out of order");

endmodule

/* rtl/hdc_classify.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdc_classify: verdict stage and output register
// Compares the distance and spans against the thresholds and holds the
// finished word until the downstream side takes it.
// ----------------------------------------------------------------------------
module hdc_classify (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hdc_pkg::cfg_t      cfg_i,
  input  logic               res_valid_i,
  input  hdc_pkg::sum_t      res_i,
  output logic               res_ready_o,
  output logic               out_valid_o,
  output hdc_pkg::out_word_t out_word_o,
  input  logic               out_stall_i
);
  import hdc_pkg::*;

  logic      out_valid_q, out_valid_d;
  out_word_t out_q;
  verdict_e  verdict;
  logic      wide_spans;
  logic      load;

  // Accept a new word when the output register is empty or draining
  assign res_ready_o = !out_valid_q || !out_stall_i;
  assign load        = res_valid_i && res_ready_o;

  // Match wins over close
  assign wide_spans = (res_i.span_first > cfg_i.span_thr) &&
                      (res_i.span_second > cfg_i.span_thr);

  always_comb begin
    priority if (res_i.distance < cfg_i.match_thr) begin
      verdict = VERDICT_MATCH;
    end else if ((res_i.distance < cfg_i.close_thr) && wide_spans) begin
      verdict = VERDICT_CLOSE;
    end else begin
      verdict = VERDICT_NONE;
    end
  end

  // Output valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q.distance    <= res_i.distance;
      out_q.verdict     <= VerdW'(verdict);
      out_q.span_first  <= res_i.span_first;
      out_q.span_second <= res_i.span_second;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // A match word really is below the match threshold
  a_match_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.verdict == VERDICT_MATCH)) |->
      (out_q.distance < cfg_i.match_thr))
    else $error("match verdict with distance at or above threshold");

  // A stalled word stays valid and unchanged
  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(out_q)))
    else $error("stalled output word changed or dropped");

  // Only defined verdict codes leave the block
  a_verdict_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_q.verdict == VERDICT_NONE) ||
                     (out_q.verdict == VERDICT_MATCH) ||
                     (out_q.verdict == VERDICT_CLOSE)))
    else $error("undefined verdict code on output");

endmodule

/* rtl/hash_distance_classifier.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hash_distance_classifier: sum of absolute differences with early exit
// Streams byte pairs of two hashes, accumulates their distance and spans,
// and emits a match / close / none verdict on the last pair.
// ----------------------------------------------------------------------------
//   channel   direction   handshake               payload
//   in        input       in_valid_i / in_stall_o    in_word_i  (byte pair)
//   out       output      out_valid_o / out_stall_i  out_word_o (verdict)
//   cfg       input       cfg_we_i                   cfg_idx_i, cfg_wdata_i
//
// One word per cycle is accepted while in_stall_o is low. A result passes the
// input register, accumulator and output register after its last word is accepted.
// The accumulator's single add-compare and min/max update sets the cycle.
// Reset clears the running state and loads the default thresholds.
// A stalled output holds its word; backpressure reaches the input only when
// a last word finds both result slots full.
// ----------------------------------------------------------------------------
module hash_distance_classifier (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  hdc_pkg::in_word_t             in_word_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output hdc_pkg::out_word_t            out_word_o,
  input  logic                          cfg_we_i,
  input  logic [hdc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [hdc_pkg::CfgDataW-1:0]  cfg_wdata_i
);
  import hdc_pkg::*;

  cfg_t     cfg_q;
  logic     in_valid_q, in_valid_d;
  in_word_t in_q;
  logic     in_ready, acc_ready;
  logic     sum_valid, sum_ready;
  sum_t     sum_word;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.match_thr <= MatchThrRst;
      cfg_q.close_thr <= CloseThrRst;
      cfg_q.span_thr  <= SpanThrRst;
      cfg_q.stop_lim  <= StopLimRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MATCH_THR: cfg_q.match_thr <= cfg_wdata_i[DistW-1:0];
        REG_CLOSE_THR: cfg_q.close_thr <= cfg_wdata_i[DistW-1:0];
        REG_SPAN_THR:  cfg_q.span_thr  <= cfg_wdata_i[ByteW-1:0];
        REG_STOP_LIM:  cfg_q.stop_lim  <= cfg_wdata_i[LimitW-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  assign in_ready   = !in_valid_q || acc_ready;
  assign in_stall_o = !in_ready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_valid_i && in_ready) begin
      in_valid_d = 1'b1;
    end else if (acc_ready) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready) begin
      in_q <= in_word_i;
    end
  end

  // Accumulate
  hdc_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stop_lim_i  (cfg_q.stop_lim),
    .in_valid_i  (in_valid_q),
    .in_word_i   (in_q),
    .in_ready_o  (acc_ready),
    .res_valid_o (sum_valid),
    .res_o       (sum_word),
    .res_ready_i (sum_ready)
  );

  // Classify and drive the output
  hdc_classify u_classify (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .res_valid_i (sum_valid),
    .res_i       (sum_word),
    .res_ready_o (sum_ready),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o),
    .out_stall_i (out_stall_i)
  );

endmodule
